>>> hdl/tet_pkg.sv
// Package for the touch event tracker: configuration and queue entry types,
// register index codes, event codes and the calibration helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tet_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  localparam logic [2:0] REG_X_SCALE    = 3'd0;
  localparam logic [2:0] REG_X_OFFSET   = 3'd1;
  localparam logic [2:0] REG_Y_SCALE    = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET   = 3'd3;
  localparam logic [2:0] REG_WIDTH      = 3'd4;
  localparam logic [2:0] REG_HEIGHT     = 3'd5;
  localparam logic [2:0] REG_TIMEOUT    = 3'd6;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [17:0]        x_scale;
    logic signed [23:0] x_offset;
    logic [17:0]        y_scale;
    logic signed [23:0] y_offset;
    logic [10:0]        x_limit;
    logic [10:0]        y_limit;
    logic [15:0]        release_ms;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic        touched;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [9:0]  cal_x;
    logic [9:0]  cal_y;
  } entry_t;

  // Adds offset and half LSB; clamps sum[31:16] to [0, min(limit,1024)-1].
  function automatic logic [9:0] calib(input logic [29:0] prod,
                                       input logic signed [23:0] offset,
                                       input logic [10:0] limit);
    logic [31:0] sum;
    logic [15:0] q;
    logic [9:0]  maxv;
    logic [9:0]  res;
    sum = {2'b00, prod} + {{8{offset[23]}}, offset} + 32'd32768;
    q   = sum[31:16];
    if (limit == 11'd0) begin
      maxv = 10'd0;
    end else if (limit > 11'd1024) begin
      maxv = 10'd1023;
    end else begin
      maxv = 10'(limit - 11'd1);
    end
    if (sum[31]) begin
      res = 10'd0;
    end else if (q > {6'd0, maxv}) begin
      res = maxv;
    end else begin
      res = q[9:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tet_in_if.sv
// Input channel of the touch event tracker: valid/ready and one input item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tet_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;
  logic        touched;
  logic [11:0] raw_x;
  logic [11:0] raw_y;

  modport source(output valid, action, now_ms, touched, raw_x, raw_y, input ready);
  modport sink(input valid, action, now_ms, touched, raw_x, raw_y, output ready);
endinterface

`default_nettype wire

>>> hdl/tet_out_if.sv
// Output channel of the touch event tracker: valid/ready and one pointer event.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tet_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [9:0]  pos_x;
  logic [9:0]  pos_y;
  logic [11:0] report_x;
  logic [11:0] report_y;
  logic [31:0] stamp_ms;

  modport source(output valid, event_kind, pos_x, pos_y, report_x, report_y, stamp_ms,
                 input ready);
  modport sink(input valid, event_kind, pos_x, pos_y, report_x, report_y, stamp_ms,
               output ready);
endinterface

`default_nettype wire

>>> hdl/tet_regs.sv
// Configuration registers of the touch event tracker behind an APB-style port.
// Depends on tet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tet_regs
  import tet_pkg::*;
#(
  parameter int unsigned AddrW = ADDR_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_X_SCALE:  cfg_d.x_scale    = pwdata[17:0];
        REG_X_OFFSET: cfg_d.x_offset   = pwdata[23:0];
        REG_Y_SCALE:  cfg_d.y_scale    = pwdata[17:0];
        REG_Y_OFFSET: cfg_d.y_offset   = pwdata[23:0];
        REG_WIDTH:    cfg_d.x_limit    = pwdata[10:0];
        REG_HEIGHT:   cfg_d.y_limit    = pwdata[10:0];
        REG_TIMEOUT:  cfg_d.release_ms = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_SCALE:  prdata = {14'd0, cfg_q.x_scale};
      REG_X_OFFSET: prdata = {8'd0, cfg_q.x_offset};
      REG_Y_SCALE:  prdata = {14'd0, cfg_q.y_scale};
      REG_Y_OFFSET: prdata = {8'd0, cfg_q.y_offset};
      REG_WIDTH:    prdata = {21'd0, cfg_q.x_limit};
      REG_HEIGHT:   prdata = {21'd0, cfg_q.y_limit};
      REG_TIMEOUT:  prdata = {16'd0, cfg_q.release_ms};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale    <= 18'd58888;
      cfg_q.x_offset   <= 24'sd1046630;
      cfg_q.y_scale    <= 18'd57677;
      cfg_q.y_offset   <= 24'sd1484869;
      cfg_q.x_limit    <= 11'd368;
      cfg_q.y_limit    <= 11'd448;
      cfg_q.release_ms <= 16'd120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/tet_front.sv
// Front end: accepts input transactions, multiplies raw coordinates by the
// gains, then rounds and clamps them into queue entries. Depends on tet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tet_front
  import tet_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  tet_in_if.sink    in_i,
  output logic      push_o,
  output entry_t    entry_o,
  input  wire logic full_i
);

  logic        s1_valid_q, s1_valid_d;
  logic        s1_action_q;
  logic [31:0] s1_now_q;
  logic        s1_touched_q;
  logic [11:0] s1_raw_x_q, s1_raw_y_q;
  logic [29:0] s1_prod_x_q, s1_prod_y_q;
  logic        in_fire;

  assign in_i.ready = !s1_valid_q || !full_i;
  assign in_fire    = in_i.valid && in_i.ready;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q  <= in_i.action;
      s1_now_q     <= in_i.now_ms;
      s1_touched_q <= in_i.touched;
      s1_raw_x_q   <= in_i.raw_x;
      s1_raw_y_q   <= in_i.raw_y;
      s1_prod_x_q  <= 30'(in_i.raw_x) * 30'(cfg_i.x_scale);
      s1_prod_y_q  <= 30'(in_i.raw_y) * 30'(cfg_i.y_scale);
    end
  end

  always_comb begin
    entry_o.action  = s1_action_q;
    entry_o.now_ms  = s1_now_q;
    entry_o.touched = s1_touched_q;
    entry_o.raw_x   = s1_raw_x_q;
    entry_o.raw_y   = s1_raw_y_q;
    entry_o.cal_x   = calib(s1_prod_x_q, cfg_i.x_offset, cfg_i.x_limit);
    entry_o.cal_y   = calib(s1_prod_y_q, cfg_i.y_offset, cfg_i.y_limit);
  end

endmodule

`default_nettype wire

>>> hdl/tet_fifo.sv
// Short queue of calibrated entries between the front end and the back end.
// Depends on tet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tet_fifo
  import tet_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    entry_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      nonempty_o,
  output entry_t    head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue count exceeds its depth.");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("Entry pushed into a full queue.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("Entry popped from an empty queue.");

endmodule

`default_nettype wire

>>> hdl/tet_back.sv
// Back end: keeps the pointer state, turns queue entries into DOWN, MOVE and
// UP events, and holds each event in an output register. Depends on tet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tet_back
  import tet_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic nonempty_i,
  input  entry_t    head_i,
  output logic      pop_o,
  tet_out_if.source out_o
);

  logic        down_q, down_d;
  logic [9:0]  last_x_q, last_x_d, last_y_q, last_y_d;
  logic [31:0] last_t_q, last_t_d;
  logic        out_valid_q, out_valid_d;
  event_kind_e kind_q, kind_d;
  logic [9:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [11:0] rep_x_q, rep_x_d, rep_y_q, rep_y_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] elapsed;
  logic        emit;

  assign pop_o   = nonempty_i && (!out_valid_q || out_o.ready);
  assign elapsed = head_i.now_ms - last_t_q;

  always_comb begin
    down_d   = down_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    last_t_d = last_t_q;
    emit     = 1'b0;
    kind_d   = EV_UP;
    pos_x_d  = last_x_q;
    pos_y_d  = last_y_q;
    rep_x_d  = {2'b00, last_x_q};
    rep_y_d  = {2'b00, last_y_q};
    stamp_d  = head_i.now_ms;
    if (head_i.action == ACT_TICK) begin
      if (down_q && (elapsed >= {16'd0, cfg_i.release_ms})) begin
        down_d = 1'b0;
        emit   = 1'b1;
      end
    end else if (head_i.touched) begin
      last_t_d = head_i.now_ms;
      pos_x_d  = head_i.cal_x;
      pos_y_d  = head_i.cal_y;
      rep_x_d  = head_i.raw_x;
      rep_y_d  = head_i.raw_y;
      if (!down_q) begin
        kind_d = EV_DOWN;
        emit   = 1'b1;
      end else if (head_i.cal_x != last_x_q || head_i.cal_y != last_y_q) begin
        kind_d = EV_MOVE;
        emit   = 1'b1;
      end
      down_d   = 1'b1;
      last_x_d = head_i.cal_x;
      last_y_d = head_i.cal_y;
    end else if (down_q) begin
      down_d = 1'b0;
      emit   = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q      <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_t_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        down_q   <= down_d;
        last_x_q <= last_x_d;
        last_y_q <= last_y_d;
        last_t_q <= last_t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q  <= kind_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      rep_x_q <= rep_x_d;
      rep_y_q <= rep_y_d;
      stamp_q <= stamp_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = kind_q;
  assign out_o.pos_x      = pos_x_q;
  assign out_o.pos_y      = pos_y_q;
  assign out_o.report_x   = rep_x_q;
  assign out_o.report_y   = rep_y_q;
  assign out_o.stamp_ms   = stamp_q;

  a_up_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit && kind_d == EV_UP) |=> !down_q)
    else $error("An UP event left the pointer down.");

  a_down_from_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit && kind_d == EV_DOWN) |-> !down_q)
    else $error("A DOWN event was issued while the pointer was down.");

  a_move_changes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit && kind_d == EV_MOVE) |-> (down_q &&
      (head_i.cal_x != last_x_q || head_i.cal_y != last_y_q)))
    else $error("A MOVE event was issued without a position change.");

endmodule

`default_nettype wire

>>> hdl/touch_event_tracker_top.sv
// Top level of the touch event tracker: registers, front end, queue, back end.
// Depends on tet_pkg, tet_in_if, tet_out_if, tet_regs, tet_front, tet_fifo, tet_back.
//
//   Port        Direction  Handshake                   Carries
//   in_i        sink       valid/ready                 action, now_ms, touched, raw_x/y
//   out_o       source     valid/ready                 event_kind, pos_x/y, report_x/y, stamp_ms
//   APB port    slave      psel/penable, pready high   seven calibration and timing registers
//
// One transaction is accepted per cycle while the queue is not full, and one event
// can leave per cycle. An input passes these steps in order: the front-end
// registers take the gain products when it is accepted, the products are rounded
// and clamped into the queue, and the back end pops the entry, updates the
// pointer state and loads the output register. The queue lets the input side keep
// accepting while the output stalls until it fills. Reset clears the pointer state
// and loads the default calibration; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module touch_event_tracker_top
  import tet_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tet_in_if.sink                 in_i,
  tet_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   nonempty;

  tet_regs #(
    .AddrW(ADDR_W)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  tet_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .push_o (push),
    .entry_o(push_entry),
    .full_i (full)
  );

  tet_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .entry_i   (push_entry),
    .full_o    (full),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .head_o    (head)
  );

  tet_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .nonempty_i(nonempty),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
